### src/msnp_pkg.sv
// Package for the masked Hamming SNP scorer.
// Holds the base codes, result kinds and field widths shared by the RTL.
// No dependencies.
package msnp_pkg;

	// bases that mask a site out of the comparison
	localparam logic [7:0] BASE_N     = 8'h4E;
	localparam logic [7:0] BASE_DASH  = 8'h2D;
	localparam logic [7:0] BASE_QMARK = 8'h3F;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DISTANCE = 2'd0,
		KIND_POSITION = 2'd1,
		KIND_COUNTER  = 2'd2
	} kind_t;

	// input modes
	typedef enum logic {
		MODE_COMPARE = 1'b0,
		MODE_READ    = 1'b1
	} mode_t;

	localparam int VALUE_W   = 33;
	localparam int DIST_W    = 16;
	localparam int COUNT_W   = 32;
	localparam int POS_W     = 15;
	localparam int NPOS_W    = 4;
	localparam int IDX_W     = 8;

	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [VALUE_W-1:0] VALUE_UNSET = '1;

	typedef logic [IDX_W-1:0] idx_t;

	// true when the base masks the site
	function automatic logic is_masked(input logic [7:0] b);
		return (b == BASE_N) || (b == BASE_DASH) || (b == BASE_QMARK);
	endfunction

endpackage

### src/msnp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read during a write to the same address returns the old data.
// No dependencies.
module msnp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/masked_hamming_snp_scorer.sv
// Masked Hamming SNP scorer top level.
// Depends on msnp_pkg and on msnp_ram for the per-site mismatch counters.
//
// Compares one aligned site per request (query base against reference base, sites masked by
// N, dash or question mark) and keeps a saturating mismatch counter per site in a RAM. The
// counter is read on acceptance and written back from stage 1, with the last write forwarded
// to a following read of the same site. On a request that marks the last site the block emits
// the distance followed by n_positions (at most MAX_POSITIONS) recorded mismatch sites (all
// ones when unset), one result per cycle while m_tready is high; a counter read (tuser set)
// emits one result. A request that emits results is held until the last result of the previous
// one has been taken, so back-to-back emitting requests run at the rate of their results. After
// reset the counter RAM is cleared one entry per cycle and s_tready stays low until it is done;
// configuration writes are taken during that time.
module masked_hamming_snp_scorer import msnp_pkg::*; #(
	parameter int MAX_SITES     = 32768,
	parameter int MAX_POSITIONS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: n_positions
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // query_base[7:0], ref_base[15:8], read_index[30:16], zero
	input  logic [0:0]  s_tuser,   // mode[0]
	input  logic        s_tlast,   // last_site
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // value[32:0] (signed), zero
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast    // last_out
);

	localparam int SITE_W = $clog2(MAX_SITES);
	localparam logic [SITE_W-1:0] SITE_LAST = SITE_W'(MAX_SITES - 1);
	localparam logic [31:0] SITES_LIMIT = 32'(MAX_SITES);
	localparam idx_t NP_MAX = IDX_W'(MAX_POSITIONS);

	// input fields
	logic [7:0]       query_base;
	logic [7:0]       ref_base;
	logic [POS_W-1:0] read_index;
	logic             mode;
	assign query_base = s_tdata[7:0];
	assign ref_base   = s_tdata[15:8];
	assign read_index = s_tdata[30:16];
	assign mode       = s_tuser[0];

	// configuration register
	logic [NPOS_W-1:0] n_positions_q;
	idx_t              np;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_positions_q <= '0;
		end else if (cfg_wr_en) begin
			n_positions_q <= cfg_wr_data;
		end
	end

	// clamp the register to the number of position slots
	assign np = ({4'b0, n_positions_q} > NP_MAX) ? NP_MAX : {4'b0, n_positions_q};

	// clearing pass over the counter RAM after reset
	logic              clearing_q;
	logic [SITE_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == SITE_LAST) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// stage 1 registers and handshake
	logic              valid_s1;
	logic              mode_s1;
	logic              mism_s1;
	logic              last_s1;
	logic              oor_s1;
	logic [SITE_W-1:0] addr_s1;
	logic              needs_emit_s1;
	logic              adv_s1;
	logic              emit_free;
	logic              accept;

	// emitter registers
	logic                busy_q;
	idx_t                idx_q;
	idx_t                np_snap_q;
	logic                read_snap_q;
	logic [VALUE_W-1:0]  head_snap_q;
	logic [POS_W-1:0]    pos_snap_q [MAX_POSITIONS];
	logic [MAX_POSITIONS-1:0] set_snap_q;

	assign needs_emit_s1 = (mode_s1 == MODE_READ) || last_s1;
	assign emit_free     = !busy_q || (m_tready && (idx_q == np_snap_q));
	assign adv_s1        = !needs_emit_s1 || emit_free;
	assign s_tready      = !clearing_q && (!valid_s1 || adv_s1);
	assign accept        = s_tvalid && s_tready;

	// fetch-side site counter, runs one request ahead of stage 1
	logic [SITE_W-1:0] site_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_q <= '0;
		end else if (accept && (mode == MODE_COMPARE)) begin
			if (s_tlast || (site_q == SITE_LAST)) begin
				site_q <= '0;
			end else begin
				site_q <= site_q + 1'b1;
			end
		end
	end

	// read address: the compared site, or the requested counter
	logic [SITE_W+POS_W-1:0] ridx_ext;
	logic [SITE_W-1:0]       rd_addr;
	logic                    oor;
	logic                    mism;

	assign ridx_ext = {{SITE_W{1'b0}}, read_index};
	assign rd_addr  = (mode == MODE_READ) ? ridx_ext[SITE_W-1:0] : site_q;
	assign oor      = {17'b0, read_index} >= SITES_LIMIT;
	assign mism     = !is_masked(query_base) && !is_masked(ref_base) &&
	                  (query_base != ref_base);

	// advance stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			mism_s1 <= mism;
			last_s1 <= s_tlast;
			oor_s1  <= oor;
			addr_s1 <= rd_addr;
		end
	end

	// counter RAM with forwarding of the most recent write
	logic                wr_en;
	logic [SITE_W-1:0]   wr_addr;
	logic [COUNT_W-1:0]  wr_data;
	logic [COUNT_W-1:0]  rd_data;
	logic                fwd_valid_q;
	logic [SITE_W-1:0]   fwd_addr_q;
	logic [COUNT_W-1:0]  fwd_data_q;
	logic [COUNT_W-1:0]  count_s1;
	logic                upd_en;

	msnp_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_SITES)
	) u_counts (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign count_s1 = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;
	assign upd_en   = valid_s1 && adv_s1 && (mode_s1 == MODE_COMPARE) && mism_s1 &&
	                  (count_s1 != COUNT_MAX);

	// clear pass owns the write port until it ends
	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = upd_en;
			wr_addr = addr_s1;
			wr_data = count_s1 + 1'b1;
		end
	end

	// hold the last write for a read issued in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	// per-sequence state: distance and first mismatch sites
	logic [DIST_W-1:0]         distance_q;
	logic [DIST_W-1:0]         dist_new;
	logic [POS_W-1:0]          pos_q [MAX_POSITIONS];
	logic [MAX_POSITIONS-1:0]  set_q;
	logic [MAX_POSITIONS-1:0]  rec;
	logic [MAX_POSITIONS-1:0]  set_new;
	logic [SITE_W+POS_W-1:0]   site_ext;
	logic [POS_W-1:0]          site_pos;
	logic                      seq_adv;

	assign seq_adv  = valid_s1 && adv_s1 && (mode_s1 == MODE_COMPARE);
	assign dist_new = (mism_s1 && (distance_q != DIST_MAX)) ? distance_q + 1'b1 : distance_q;
	assign site_ext = {{POS_W{1'b0}}, addr_s1};
	assign site_pos = site_ext[POS_W-1:0];

	// pick the slot that this mismatch fills
	always_comb begin
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			rec[i] = mism_s1 && (dist_new == DIST_W'(i + 1)) && (IDX_W'(i) < np) && !set_q[i];
		end
		set_new = set_q | rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_q <= '0;
			set_q      <= '0;
		end else if (seq_adv) begin
			if (last_s1) begin
				distance_q <= '0;
				set_q      <= '0;
			end else begin
				distance_q <= dist_new;
				set_q      <= set_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			if (seq_adv && rec[i]) begin
				pos_q[i] <= site_pos;
			end
		end
	end

	// emitter: load a run of results, step through them as they are taken
	logic load;
	assign load = valid_s1 && adv_s1 && needs_emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (idx_q == np_snap_q) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			read_snap_q <= (mode_s1 == MODE_READ);
			if (mode_s1 == MODE_READ) begin
				np_snap_q   <= '0;
				head_snap_q <= oor_s1 ? '0 : {1'b0, count_s1};
			end else begin
				np_snap_q   <= np;
				head_snap_q <= {{(VALUE_W-DIST_W){1'b0}}, dist_new};
			end
			set_snap_q <= set_new;
			for (int i = 0; i < MAX_POSITIONS; i++) begin
				pos_snap_q[i] <= rec[i] ? site_pos : pos_q[i];
			end
		end
	end

	// result selection
	logic [VALUE_W-1:0] value;
	kind_t              kind;
	idx_t               slot;

	assign slot = idx_q - 1'b1;

	always_comb begin
		value = head_snap_q;
		kind  = read_snap_q ? KIND_COUNTER : KIND_DISTANCE;
		if (idx_q != '0) begin
			kind  = KIND_POSITION;
			value = VALUE_UNSET;
			for (int i = 0; i < MAX_POSITIONS; i++) begin
				if ((slot == IDX_W'(i)) && set_snap_q[i]) begin
					value = {{(VALUE_W-POS_W){1'b0}}, pos_snap_q[i]};
				end
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {7'b0, value};
	assign m_tuser  = kind;
	assign m_tlast  = (idx_q == np_snap_q);

endmodule

### verif/masked_hamming_snp_scorer_tb.sv
// Self-checking testbench for masked_hamming_snp_scorer.
// Depends on msnp_pkg and the scorer RTL. A scoreboard class predicts the result
// stream from the accepted requests; plain tasks drive the input stream and the register.
module masked_hamming_snp_scorer_tb;
	import msnp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SITES     = 32768;
	localparam int MAX_POS       = 8;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 120;
	localparam logic [7:0] BASE_A = "A";
	localparam logic [7:0] BASE_C = "C";
	localparam logic [7:0] BASE_G = "G";
	localparam logic [7:0] BASE_T = "T";

	typedef struct {
		mode_t       mode;
		logic [7:0]  query;
		logic [7:0]  ref_base;
		logic        last;
		logic [14:0] read_idx;
	} site_req_t;

	typedef struct {
		kind_t       kind;
		logic [32:0] value;
		logic        last;
	} score_t;

	// Predicts the score stream and checks each result against it
	class snp_score_tracker;
		logic [14:0] site_pos;
		logic [15:0] seq_dist;
		logic [15:0] first_hits [MAX_POS];
		bit   [31:0] site_hits [MAX_SITES];
		logic [3:0]  npos;
		score_t      awaited [$];
		int          errors;
		int          n_scores;

		function new();
			clear_sequence();
			npos = '0;
			errors = 0;
			n_scores = 0;
		endfunction

		function void clear_sequence();
			site_pos = '0;
			seq_dist = '0;
			foreach (first_hits[i]) first_hits[i] = '1;
		endfunction

		function void set_npos(logic [3:0] v);
			npos = v;
		endfunction

		function bit masked(logic [7:0] b);
			return b == BASE_N || b == BASE_DASH || b == BASE_QMARK;
		endfunction

		function void push(kind_t kind, logic [32:0] value, logic last);
			score_t s;
			s.kind = kind;
			s.value = value;
			s.last = last;
			awaited.push_back(s);
		endfunction

		// Note one accepted request and queue the scores it causes
		function void note_site(site_req_t req);
			int np;
			np = (npos > MAX_POS) ? MAX_POS : int'(npos);
			if (req.mode == MODE_READ) begin
				push(KIND_COUNTER, {1'b0, site_hits[req.read_idx]}, 1'b1);
				return;
			end
			// count a mismatch at an unmasked site
			if (!masked(req.query) && !masked(req.ref_base) && req.query != req.ref_base) begin
				if (seq_dist != '1) seq_dist = seq_dist + 1'b1;
				if (site_hits[site_pos] != '1) site_hits[site_pos] = site_hits[site_pos] + 1;
				if (seq_dist >= 1 && seq_dist <= np && first_hits[seq_dist - 1] == '1)
					first_hits[seq_dist - 1] = {1'b0, site_pos};
			end
			site_pos = site_pos + 1'b1;
			if (!req.last) return;
			// emit distance, then the recorded sites
			push(KIND_DISTANCE, {17'b0, seq_dist}, np == 0);
			for (int i = 0; i < np; i++) begin
				push(KIND_POSITION, (first_hits[i] == '1) ? '1 : {17'b0, first_hits[i]},
					i + 1 == np);
			end
			clear_sequence();
		endfunction

		// Check one accepted result against the oldest expected score
		function void check_score(kind_t kind, logic [32:0] value, logic last);
			score_t s;
			n_scores++;
			if (awaited.size() == 0) begin
				$error("unexpected result: kind %0d value %0h last %0b", kind, value, last);
				errors++;
				return;
			end
			s = awaited.pop_front();
			if (kind !== s.kind) begin
				$error("kind: expected %0d, got %0d", s.kind, kind);
				errors++;
			end
			if (value !== s.value) begin
				$error("value: expected %0h, got %0h", s.value, value);
				errors++;
			end
			if (last !== s.last) begin
				$error("last_out: expected %0b, got %0b", s.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [3:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asks = 0;
	int sent_count = 0;

	snp_score_tracker tracker = new();

	masked_hamming_snp_scorer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Observe both streams in one process so a request is noted before its scores
	always @(posedge clk) begin
		site_req_t req;
		if (arst_n && s_tvalid && s_tready) begin
			req.mode = mode_t'(s_tuser[0]);
			req.query = s_tdata[7:0];
			req.ref_base = s_tdata[15:8];
			req.read_idx = s_tdata[30:16];
			req.last = s_tlast;
			tracker.note_site(req);
		end
		if (arst_n && m_tvalid && m_tready)
			tracker.check_score(kind_t'(m_tuser), m_tdata[32:0], m_tlast);
	end

	// Drive result ready; hold it low for a long stretch when asked
	initial begin
		int holds_done;
		holds_done = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic site_req_t site(mode_t mode, logic [7:0] q, logic [7:0] r, logic last,
		logic [14:0] idx);
		site_req_t req;
		req.mode = mode;
		req.query = q;
		req.ref_base = r;
		req.last = last;
		req.read_idx = idx;
		return req;
	endfunction

	function automatic logic [7:0] pick_base();
		case ($urandom_range(11))
			0: return BASE_N;
			1: return BASE_DASH;
			2: return BASE_QMARK;
			3, 4: return 8'($urandom);
			5, 6: return BASE_A;
			7: return BASE_C;
			8, 9: return BASE_G;
			default: return BASE_T;
		endcase
	endfunction

	// Short sequences with random bases, interleaved counter reads
	function automatic site_req_t random_site();
		site_req_t req;
		req.mode = ($urandom_range(3) == 0) ? MODE_READ : MODE_COMPARE;
		req.query = pick_base();
		req.ref_base = pick_base();
		req.last = ($urandom_range(5) == 0);
		req.read_idx = ($urandom_range(1) == 0) ? 15'($urandom_range(63)) : 15'($urandom);
		return req;
	endfunction

	// Offer one request, idling first at random, and wait for its handshake
	task automatic send_site(input site_req_t req);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, req.read_idx, req.ref_base, req.query};
		s_tuser <= req.mode;
		s_tlast <= req.last;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// Stop offering and wait until every expected score has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_npos(input logic [3:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_npos(v);
	endtask

	task automatic run_phase(input int n, input int src_pct, input int snk_pct);
		idle_pct = src_pct;
		stall_pct = snk_pct;
		repeat (n) send_site(random_site());
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		s_tlast <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full position list, masks, byte extremes, untouched counters
		write_npos(4'd8);
		send_site(site(MODE_READ, 8'h00, 8'h00, 1'b0, 15'd0));
		send_site(site(MODE_READ, 8'hFF, 8'hFF, 1'b1, 15'h7FFF));
		send_site(site(MODE_COMPARE, BASE_A, BASE_C, 1'b0, 15'h7FFF));
		send_site(site(MODE_COMPARE, BASE_N, BASE_A, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_A, BASE_DASH, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_QMARK, BASE_QMARK, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_G, BASE_G, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_T, BASE_G, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, 8'hFF, 8'h00, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, 8'h00, 8'h00, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_C, BASE_A, 1'b1, 15'd0));
		send_site(site(MODE_READ, BASE_A, BASE_C, 1'b1, 15'd5));
		// single matching site: distance zero, every position unset
		send_site(site(MODE_COMPARE, BASE_T, BASE_T, 1'b1, 15'd0));
		wait_drained();
		// no positions recorded: distance alone carries last_out
		write_npos(4'd0);
		send_site(site(MODE_COMPARE, BASE_A, BASE_G, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_C, BASE_T, 1'b1, 15'd0));
		wait_drained();
		// register above the position count, then changed inside a sequence
		write_npos(4'd15);
		send_site(site(MODE_COMPARE, BASE_G, BASE_A, 1'b0, 15'd0));
		send_site(site(MODE_COMPARE, BASE_T, BASE_C, 1'b0, 15'd0));
		wait_drained();
		write_npos(4'd1);
		send_site(site(MODE_COMPARE, BASE_C, BASE_G, 1'b1, 15'd0));
		send_site(site(MODE_READ, BASE_A, BASE_A, 1'b0, 15'd1));
		wait_drained();

		// random phases under different idle and stall mixes
		write_npos(4'd3);
		run_phase(30, 0, 0);
		write_npos(4'd8);
		run_phase(30, 54, 0);
		write_npos(4'd15);
		run_phase(30, 0, 54);
		write_npos(4'd5);
		run_phase(25, 7, 7);

		// back-pressure: hold results off while requests keep coming, then pause
		write_npos(4'd2);
		idle_pct = 0;
		stall_pct = 0;
		hold_asks++;
		repeat (25) send_site(random_site());
		wait_drained();
		repeat (10) send_site(random_site());
		wait_drained();

		write_npos(4'd4);
		run_phase(15, 20, 20);

		$display("covered %0d requests and %0d results: directed cases, five idle mixes,",
			sent_count, tracker.n_scores);
		$display("a long held-off receiver and pauses until every result was taken");
		if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### masked_hamming_snp_scorer.f
src/msnp_pkg.sv
src/msnp_ram.sv
src/masked_hamming_snp_scorer.sv
verif/masked_hamming_snp_scorer_tb.sv
